// ----- design/artt_pkg.sv -----
// ----------------------------------------------------------------------------
// artt_pkg: shared types and constants for the ack retry timeout table
// Table geometry, field widths, operation and event codes, and the entry
// layout kept in the entry RAM.
// ----------------------------------------------------------------------------
package artt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int SLOT_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int ID_W    = 32;
  localparam int RETRY_W = 4;
  localparam int AGE_W   = 16;
  localparam int CFG_W   = 16;

  localparam logic [AGE_W-1:0]   AGE_MAX           = '1;
  localparam logic [AGE_W-1:0]   TIMEOUT_RESET     = 16'd10;
  localparam logic [RETRY_W-1:0] RETRY_LIMIT_RESET = 4'd3;

  typedef enum logic [1:0] {
    OP_SEND = 2'd0,
    OP_ACK  = 2'd1,
    OP_TICK = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    EV_REGISTERED  = 3'd0,
    EV_ACKED       = 3'd1,
    EV_ACK_UNKNOWN = 3'd2,
    EV_RESEND      = 3'd3,
    EV_UNDELIVERED = 3'd4,
    EV_FULL        = 3'd5,
    EV_TICK_DONE   = 3'd6
  } event_t;

  typedef enum logic {
    CFG_TIMEOUT     = 1'b0,
    CFG_RETRY_LIMIT = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [RETRY_W-1:0] retries;
    logic [AGE_W-1:0]   age;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    event_t             ev;
    logic [ID_W-1:0]    id;
    logic [RETRY_W-1:0] retries;
    logic               last;
  } result_t;

endpackage

// ----- design/artt_ram.sv -----
// ----------------------------------------------------------------------------
// artt_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// Read data holds while the read enable is low.
// ----------------------------------------------------------------------------
module artt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/ack_retry_timeout_table_top.sv -----
// ----------------------------------------------------------------------------
// ack_retry_timeout_table_top: table of sent messages awaiting acknowledgement
// Sends register ids, acks remove them, ticks age every entry and report
// resends and undelivered messages in slot order, closed by a done marker.
//
//   channel   dir  handshake           contents
//   s_*       in   s_tvalid/s_tready   tuser: operation, tdata: msg_id
//   m_*       out  m_tvalid/m_tready   tuser: event_res, tdata: id, retries
//   cfg_*     in   cfg_we              cfg_index selects register, cfg_data
//
// Every accepted send, ack or tick scans the entry RAM one slot per cycle while
// the output is not stalled, set by the single RAM read port. Unused operation
// codes are accepted and dropped without a scan or a report.
// Reset clears control state and config, not the RAM; RAM data is used only when valid.
// A stalled m_tready holds the scan; a new item is taken while the last
// result still waits in the output register.
// ----------------------------------------------------------------------------
module ack_retry_timeout_table_top (
  input  logic                         clk,
  input  logic                         rst,
  // input stream
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [31:0]                  s_tdata,   // [31:0] msg_id
  input  logic [1:0]                   s_tuser,   // [1:0] operation
  // output stream
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [39:0]                  m_tdata,   // [31:0] event_id, [35:32] retry_count
  output logic [2:0]                   m_tuser,   // [2:0] event_res
  output logic                         m_tlast,
  // configuration
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [artt_pkg::CFG_W-1:0]   cfg_data
);

  artt_pkg::state_t state, state_next;

  artt_pkg::op_t                       op;
  logic [artt_pkg::ID_W-1:0]           req_id;
  logic [artt_pkg::AGE_W-1:0]          timeout_ticks;
  logic [artt_pkg::RETRY_W-1:0]        retry_limit;
  logic [artt_pkg::TABLE_DEPTH-1:0]    valid;

  logic [artt_pkg::CNT_W-1:0]          iss_cnt;
  logic                                eval_valid;
  logic [artt_pkg::SLOT_W-1:0]         eval_slot;

  logic                                hit;
  logic [artt_pkg::SLOT_W-1:0]         hit_slot;
  logic [artt_pkg::RETRY_W-1:0]        hit_retries;

  logic                                out_valid;
  artt_pkg::result_t                   out_res;

  // RAM ports
  logic                                ram_re;
  logic [artt_pkg::SLOT_W-1:0]         ram_raddr;
  artt_pkg::entry_t                    ram_rdata;
  logic                                ram_we;
  logic [artt_pkg::SLOT_W-1:0]         ram_waddr;
  artt_pkg::entry_t                    ram_wdata;

  // datapath control
  logic                                accept;
  logic                                out_free;
  logic                                eval_go;
  logic                                issue;
  logic                                scan_done;
  logic                                slot_valid;
  logic                                id_match;
  logic [artt_pkg::AGE_W-1:0]          age_inc;
  logic [artt_pkg::RETRY_W-1:0]        retries_inc;
  logic                                timed_out;
  logic                                give_up;
  logic                                free_any;
  logic [artt_pkg::SLOT_W-1:0]         free_slot;
  logic                                res_load;
  artt_pkg::result_t                   res_next;
  logic                                valid_set;
  logic                                valid_clr;
  logic [artt_pkg::SLOT_W-1:0]         valid_slot;

  artt_ram #(
    .WIDTH (artt_pkg::ENTRY_W),
    .DEPTH (artt_pkg::TABLE_DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign s_tready = (state == artt_pkg::ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0000, out_res.retries, out_res.id};
  assign m_tuser  = out_res.ev;
  assign m_tlast  = out_res.last;

  assign out_free  = !out_valid || m_tready;
  assign eval_go   = eval_valid && out_free;
  assign scan_done = (iss_cnt == artt_pkg::CNT_W'(artt_pkg::TABLE_DEPTH));
  assign issue     = (state == artt_pkg::ST_SCAN) && !scan_done && (!eval_valid || eval_go);
  assign ram_re    = issue;
  assign ram_raddr = iss_cnt[artt_pkg::SLOT_W-1:0];

  assign slot_valid  = valid[eval_slot];
  assign id_match    = slot_valid && (ram_rdata.id == req_id);
  assign age_inc     = (ram_rdata.age == artt_pkg::AGE_MAX) ? ram_rdata.age
                                                            : ram_rdata.age + 1'b1;
  assign retries_inc = ram_rdata.retries + 1'b1;
  assign timed_out   = (age_inc >= timeout_ticks);
  assign give_up     = (ram_rdata.retries >= retry_limit);

  // lowest free slot
  always_comb begin
    free_any  = 1'b0;
    free_slot = '0;
    for (int i = artt_pkg::TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_any  = 1'b1;
        free_slot = artt_pkg::SLOT_W'(i);
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      artt_pkg::ST_IDLE: begin
        if (accept && (s_tuser == artt_pkg::OP_SEND || s_tuser == artt_pkg::OP_ACK ||
                       s_tuser == artt_pkg::OP_TICK)) begin
          state_next = artt_pkg::ST_SCAN;
        end
      end
      artt_pkg::ST_SCAN: begin
        if (scan_done && !eval_valid) begin
          state_next = artt_pkg::ST_FINISH;
        end
      end
      artt_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = artt_pkg::ST_IDLE;
        end
      end
      default: state_next = artt_pkg::ST_IDLE;
    endcase
  end

  // per-slot evaluation and final result
  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = eval_slot;
    ram_wdata  = ram_rdata;
    res_load   = 1'b0;
    res_next   = '0;
    valid_set  = 1'b0;
    valid_clr  = 1'b0;
    valid_slot = eval_slot;
    unique case (state)
      artt_pkg::ST_SCAN: begin
        if (eval_go && op == artt_pkg::OP_TICK && slot_valid) begin
          if (timed_out) begin
            res_load = 1'b1;
            if (give_up) begin
              valid_clr = 1'b1;
              res_next  = '{ev: artt_pkg::EV_UNDELIVERED, id: ram_rdata.id,
                            retries: ram_rdata.retries, last: 1'b0};
            end else begin
              ram_we    = 1'b1;
              ram_wdata = '{id: ram_rdata.id, retries: retries_inc, age: '0};
              res_next  = '{ev: artt_pkg::EV_RESEND, id: ram_rdata.id,
                            retries: retries_inc, last: 1'b0};
            end
          end else begin
            ram_we    = 1'b1;
            ram_wdata = '{id: ram_rdata.id, retries: ram_rdata.retries, age: age_inc};
          end
        end
      end
      artt_pkg::ST_FINISH: begin
        if (out_free) begin
          res_load = 1'b1;
          case (op)
            artt_pkg::OP_TICK: begin
              res_next = '{ev: artt_pkg::EV_TICK_DONE, id: '0, retries: '0, last: 1'b1};
            end
            artt_pkg::OP_ACK: begin
              if (hit) begin
                valid_clr  = 1'b1;
                valid_slot = hit_slot;
                res_next   = '{ev: artt_pkg::EV_ACKED, id: req_id,
                               retries: hit_retries, last: 1'b1};
              end else begin
                res_next   = '{ev: artt_pkg::EV_ACK_UNKNOWN, id: req_id,
                               retries: '0, last: 1'b1};
              end
            end
            artt_pkg::OP_SEND: begin
              if (hit || free_any) begin
                ram_we     = 1'b1;
                ram_waddr  = hit ? hit_slot : free_slot;
                ram_wdata  = '{id: req_id, retries: '0, age: '0};
                valid_set  = 1'b1;
                valid_slot = hit ? hit_slot : free_slot;
                res_next   = '{ev: artt_pkg::EV_REGISTERED, id: req_id,
                               retries: '0, last: 1'b1};
              end else begin
                res_next   = '{ev: artt_pkg::EV_FULL, id: req_id,
                               retries: '0, last: 1'b1};
              end
            end
            default: res_load = 1'b0;
          endcase
        end
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= artt_pkg::ST_IDLE;
      valid         <= '0;
      out_valid     <= 1'b0;
      eval_valid    <= 1'b0;
      iss_cnt       <= '0;
      hit           <= 1'b0;
      timeout_ticks <= artt_pkg::TIMEOUT_RESET;
      retry_limit   <= artt_pkg::RETRY_LIMIT_RESET;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        unique case (artt_pkg::cfg_idx_t'(cfg_index))
          artt_pkg::CFG_TIMEOUT:     timeout_ticks <= cfg_data;
          artt_pkg::CFG_RETRY_LIMIT: retry_limit   <= cfg_data[artt_pkg::RETRY_W-1:0];
          default: ;
        endcase
      end

      if (accept) begin
        iss_cnt    <= '0;
        hit        <= 1'b0;
        eval_valid <= 1'b0;
      end else begin
        if (issue) begin
          iss_cnt <= iss_cnt + 1'b1;
        end
        if (issue) begin
          eval_valid <= 1'b1;
        end else if (eval_go) begin
          eval_valid <= 1'b0;
        end
        // first matching slot; ids are unique in the table
        if (eval_go && op != artt_pkg::OP_TICK && id_match && !hit) begin
          hit <= 1'b1;
        end
      end

      if (valid_clr) begin
        valid[valid_slot] <= 1'b0;
      end else if (valid_set) begin
        valid[valid_slot] <= 1'b1;
      end

      if (res_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op     <= artt_pkg::op_t'(s_tuser);
      req_id <= s_tdata;
    end
    if (issue) begin
      eval_slot <= iss_cnt[artt_pkg::SLOT_W-1:0];
    end
    if (eval_go && op != artt_pkg::OP_TICK && id_match && !hit) begin
      hit_slot    <= eval_slot;
      hit_retries <= ram_rdata.retries;
    end
    if (res_load) begin
      out_res <= res_next;
    end
  end

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking regression for ack_retry_timeout_table_top
// A queue-fed driver sends send/ack/tick transactions. A shadow copy of the
// retry table predicts every event report, and a monitor checks each output
// transaction field by field. Configuration changes only while the table is
// quiet. Both sides get random stalls, one phase runs without stalls, and
// one phase blocks the output for a long stretch to back up the input.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CLK_HALF      = 2;
  localparam int          RESET_CYCLES  = 10;
  localparam int          SETTLE_CYCLES = 48;
  localparam int          HOLD_CYCLES   = 400;
  localparam int          WATCHDOG_MAX  = 2000;
  localparam int          IDLE_PCT      = 31;
  localparam int          ID_POOL_SIZE  = 20;
  localparam logic [1:0]  OP_UNUSED     = 2'd3;

  typedef struct {
    logic [1:0]                op;
    logic [artt_pkg::ID_W-1:0] id;
  } msg_item_t;

  logic                          clk       = 1'b0;
  logic                          rst       = 1'b1;
  logic                          s_tvalid  = 1'b0;
  logic                          s_tready;
  logic [31:0]                   s_tdata   = '0;
  logic [1:0]                    s_tuser   = '0;
  logic                          m_tvalid;
  logic                          m_tready  = 1'b0;
  logic [39:0]                   m_tdata;
  logic [2:0]                    m_tuser;
  logic                          m_tlast;
  logic                          cfg_we    = 1'b0;
  logic                          cfg_index = 1'b0;
  logic [artt_pkg::CFG_W-1:0]    cfg_data  = '0;

  // shadow table and configuration
  logic                          tbl_valid   [artt_pkg::TABLE_DEPTH];
  logic [artt_pkg::ID_W-1:0]     tbl_id      [artt_pkg::TABLE_DEPTH];
  logic [artt_pkg::RETRY_W-1:0]  tbl_retries [artt_pkg::TABLE_DEPTH];
  logic [artt_pkg::AGE_W-1:0]    tbl_age     [artt_pkg::TABLE_DEPTH];
  logic [artt_pkg::AGE_W-1:0]    cur_timeout = artt_pkg::TIMEOUT_RESET;
  logic [artt_pkg::RETRY_W-1:0]  cur_limit   = artt_pkg::RETRY_LIMIT_RESET;

  msg_item_t                     stim_q[$];
  artt_pkg::result_t             event_q[$];
  logic [artt_pkg::ID_W-1:0]     id_pool[ID_POOL_SIZE];

  int                  pushed_cnt   = 0;
  int                  accepted_cnt = 0;
  int                  err_cnt      = 0;
  int                  idle_cycles  = 0;
  bit                  calm         = 1'b0;
  bit                  pressure_go  = 1'b0;
  logic                hold_rx      = 1'b0;

  ack_retry_timeout_table_top u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  function automatic void log_event(artt_pkg::event_t ev, logic [artt_pkg::ID_W-1:0] id,
                                    logic [artt_pkg::RETRY_W-1:0] rc, logic lst);
    artt_pkg::result_t r;
    r.ev      = ev;
    r.id      = id;
    r.retries = rc;
    r.last    = lst;
    event_q = {event_q, r};
  endfunction

  function automatic int find_entry(logic [artt_pkg::ID_W-1:0] id);
    for (int s = 0; s < artt_pkg::TABLE_DEPTH; s++) begin
      if (tbl_valid[s] && tbl_id[s] == id) return s;
    end
    return -1;
  endfunction

  // apply one accepted transaction to the shadow table, queue its reports
  function automatic void table_update(logic [1:0] op, logic [artt_pkg::ID_W-1:0] id);
    int slot;
    slot = find_entry(id);
    case (op)
      artt_pkg::OP_SEND: begin
        if (slot < 0) begin
          for (int s = artt_pkg::TABLE_DEPTH - 1; s >= 0; s--) begin
            if (!tbl_valid[s]) slot = s;
          end
        end
        if (slot < 0) begin
          log_event(artt_pkg::EV_FULL, id, '0, 1'b1);
        end else begin
          tbl_valid[slot]   = 1'b1;
          tbl_id[slot]      = id;
          tbl_retries[slot] = '0;
          tbl_age[slot]     = '0;
          log_event(artt_pkg::EV_REGISTERED, id, '0, 1'b1);
        end
      end
      artt_pkg::OP_ACK: begin
        if (slot < 0) begin
          log_event(artt_pkg::EV_ACK_UNKNOWN, id, '0, 1'b1);
        end else begin
          tbl_valid[slot] = 1'b0;
          log_event(artt_pkg::EV_ACKED, id, tbl_retries[slot], 1'b1);
        end
      end
      artt_pkg::OP_TICK: begin
        for (int s = 0; s < artt_pkg::TABLE_DEPTH; s++) begin
          if (tbl_valid[s]) begin
            if (tbl_age[s] != artt_pkg::AGE_MAX) tbl_age[s] = tbl_age[s] + 1'b1;
            if (tbl_age[s] >= cur_timeout) begin
              if (tbl_retries[s] >= cur_limit) begin
                tbl_valid[s] = 1'b0;
                log_event(artt_pkg::EV_UNDELIVERED, tbl_id[s], tbl_retries[s], 1'b0);
              end else begin
                tbl_retries[s] = tbl_retries[s] + 1'b1;
                tbl_age[s]     = '0;
                log_event(artt_pkg::EV_RESEND, tbl_id[s], tbl_retries[s], 1'b0);
              end
            end
          end
        end
        log_event(artt_pkg::EV_TICK_DONE, '0, '0, 1'b1);
      end
      default: ;  // unused code, dropped
    endcase
  endfunction

  function automatic void note_error(string what);
    err_cnt++;
    if (err_cnt <= 10) $display("ERROR @%0t: %s", $realtime, what);
  endfunction

  // input driver
  always @(posedge clk) begin
    msg_item_t it;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        table_update(s_tuser, s_tdata);
        accepted_cnt++;
      end
      if (!s_tvalid || s_tready) begin
        if (stim_q.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          it = stim_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= it.id;
          s_tuser  <= it.op;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // output backpressure
  always @(posedge clk) begin
    m_tready <= !hold_rx && (calm || $urandom_range(99) >= IDLE_PCT);
  end

  // output monitor
  always @(posedge clk) begin
    artt_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (event_q.size() == 0) begin
        note_error($sformatf("unexpected event ev=%0d id=%h rc=%0d last=%b",
                             m_tuser, m_tdata[31:0], m_tdata[35:32], m_tlast));
      end else begin
        want = event_q.pop_front();
        if (m_tuser != want.ev || m_tdata[31:0] != want.id ||
            m_tdata[35:32] != want.retries || m_tdata[39:36] != '0 ||
            m_tlast != want.last) begin
          note_error($sformatf(
            "event mismatch: exp ev=%0d id=%h rc=%0d last=%b, got ev=%0d id=%h rc=%0d last=%b pad=%h",
            want.ev, want.id, want.retries, want.last,
            m_tuser, m_tdata[31:0], m_tdata[35:32], m_tlast, m_tdata[39:36]));
        end
      end
    end
  end

  // watchdog on cycles with no transaction anywhere
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_MAX) begin
      $display("timeout: no transaction for %0d cycles", WATCHDOG_MAX);
      $display("ack_retry_timeout_table_top regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // long output stall so the table backs up into the input
  initial begin
    while (!pressure_go) @(posedge clk);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
  end

  task automatic queue_item(logic [1:0] op, logic [artt_pkg::ID_W-1:0] id);
    msg_item_t it;
    it.op = op;
    it.id = id;
    stim_q = {stim_q, it};
    pushed_cnt++;
  endtask

  task automatic queue_random(int n);
    int r;
    logic [artt_pkg::ID_W-1:0] id;
    for (int k = 0; k < n; k++) begin
      // mostly pooled ids so sends, acks and timeouts hit live entries
      id = ($urandom_range(99) < 85) ? id_pool[$urandom_range(ID_POOL_SIZE - 1)]
                                     : $urandom;
      r = $urandom_range(99);
      if (r < 40)      queue_item(artt_pkg::OP_TICK, $urandom);
      else if (r < 70) queue_item(artt_pkg::OP_SEND, id);
      else if (r < 93) queue_item(artt_pkg::OP_ACK, id);
      else             queue_item(OP_UNUSED, id);
    end
  endtask

  task automatic write_reg(artt_pkg::cfg_idx_t idx, logic [artt_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == artt_pkg::CFG_TIMEOUT) cur_timeout = val;
    else                              cur_limit   = val[artt_pkg::RETRY_W-1:0];
  endtask

  // wait until every item is taken and every report is in, then settle
  task automatic drain();
    while (accepted_cnt != pushed_cnt || event_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    for (int s = 0; s < artt_pkg::TABLE_DEPTH; s++) begin
      tbl_valid[s]   = 1'b0;
      tbl_id[s]      = '0;
      tbl_retries[s] = '0;
      tbl_age[s]     = '0;
    end
    id_pool[0] = '0;
    id_pool[1] = '1;
    for (int k = 2; k < ID_POOL_SIZE; k++) id_pool[k] = $urandom;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed: send, duplicate send, acks, unused code, timeout, full table
    write_reg(artt_pkg::CFG_TIMEOUT, 16'd2);
    write_reg(artt_pkg::CFG_RETRY_LIMIT, 16'd1);
    queue_item(artt_pkg::OP_SEND, 32'h0000_0000);
    queue_item(artt_pkg::OP_SEND, 32'hFFFF_FFFF);
    queue_item(artt_pkg::OP_SEND, 32'h0000_0000);
    queue_item(artt_pkg::OP_ACK, 32'hFFFF_FFFF);
    queue_item(artt_pkg::OP_ACK, 32'h5A5A_0F0F);
    queue_item(OP_UNUSED, 32'hA5A5_F0F0);
    queue_item(artt_pkg::OP_TICK, 32'h0000_0000);
    queue_item(artt_pkg::OP_TICK, 32'hFFFF_FFFF);
    for (int k = 1; k <= artt_pkg::TABLE_DEPTH; k++) begin
      queue_item(artt_pkg::OP_SEND, 32'h8000_0000 + k);
    end
    drain();

    // zero timeout, zero retries: one tick flushes the whole table
    write_reg(artt_pkg::CFG_TIMEOUT, 16'd0);
    write_reg(artt_pkg::CFG_RETRY_LIMIT, 16'd0);
    queue_item(artt_pkg::OP_TICK, 32'h0000_0000);
    drain();

    write_reg(artt_pkg::CFG_TIMEOUT, 16'd1);
    write_reg(artt_pkg::CFG_RETRY_LIMIT, 16'd15);
    queue_random(40);
    drain();

    // no stalls on either side
    write_reg(artt_pkg::CFG_TIMEOUT, 16'd3);
    write_reg(artt_pkg::CFG_RETRY_LIMIT, 16'd2);
    calm = 1'b1;
    queue_random(40);
    drain();
    calm = 1'b0;

    write_reg(artt_pkg::CFG_TIMEOUT, 16'hFFFF);
    write_reg(artt_pkg::CFG_RETRY_LIMIT, 16'd0);
    queue_random(40);
    pressure_go = 1'b1;
    drain();

    write_reg(artt_pkg::CFG_TIMEOUT, 16'd4);
    write_reg(artt_pkg::CFG_RETRY_LIMIT, 16'd3);
    queue_random(25);
    drain();

    if (err_cnt == 0) begin
      $display("ack_retry_timeout_table_top regression: pass");
    end else begin
      $display("ack_retry_timeout_table_top regression: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/artt_pkg.sv
design/artt_ram.sv
design/ack_retry_timeout_table_top.sv
tb/sv/testbench.sv
